// ===== hw/rtl/sbs_pkg.sv =====
// Shared types and constants for the stable bucket sort block.
// No dependencies.
package sbs_pkg;
	localparam int IdW  = 32;
	localparam int KeyW = 8;
	localparam int StW  = 3;
	localparam logic [KeyW-1:0] MinKeyReset = 8'd18;

	typedef enum logic [StW-1:0] {
		ST_LOADED = 3'd0,
		ST_ITEM   = 3'd1,
		ST_RANGE  = 3'd2,
		ST_FULL   = 3'd3,
		ST_BUSY   = 3'd4,
		ST_EMPTY  = 3'd5
	} status_t;

	typedef struct packed {
		logic            mode;
		logic [IdW-1:0]  record_id;
		logic [KeyW-1:0] record_key;
	} in_item_t;

	typedef struct packed {
		logic [StW-1:0]  status;
		logic [IdW-1:0]  out_id;
		logic [KeyW-1:0] out_key;
		logic            last_item;
	} out_item_t;
endpackage

// ===== hw/rtl/sbs_if.sv =====
// Valid/ready channel interfaces for the stable bucket sort block.
// Depends on sbs_pkg.
interface sbs_in_if;
	import sbs_pkg::*;
	logic     valid;
	logic     ready;
	logic     mode;
	logic [IdW-1:0]  record_id;
	logic [KeyW-1:0] record_key;
	modport source (output valid, mode, record_id, record_key, input ready);
	modport sink   (input valid, mode, record_id, record_key, output ready);
endinterface

interface sbs_out_if;
	import sbs_pkg::*;
	logic     valid;
	logic     ready;
	logic [StW-1:0]  status;
	logic [IdW-1:0]  out_id;
	logic [KeyW-1:0] out_key;
	logic     last_item;
	modport source (output valid, status, out_id, out_key, last_item, input ready);
	modport sink   (input valid, status, out_id, out_key, last_item, output ready);
endinterface

interface sbs_cfg_if;
	import sbs_pkg::*;
	logic     valid;
	logic     ready;
	logic [KeyW-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/sbs_front.sv =====
// Front end: accepts input beats into a two-entry queue.
// Depends on sbs_pkg.
module sbs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sbs_pkg::in_item_t in_item,
	output logic              q_valid,
	input  logic              q_pop,
	output sbs_pkg::in_item_t q_item
);
	import sbs_pkg::*;

	in_item_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("fill count");
endmodule

// ===== hw/rtl/sbs_back.sv =====
// Back end: record store, bucket lists, load and drain sequencer.
// Depends on sbs_pkg.
module sbs_back #(
	parameter int MAX_ITEMS = 1024,
	parameter int NUM_KEYS  = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [sbs_pkg::KeyW-1:0] min_key,
	input  logic               q_valid,
	output logic               q_pop,
	input  sbs_pkg::in_item_t  q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output sbs_pkg::out_item_t out_item
);
	import sbs_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int BW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	logic [IdW-1:0]  id_mem   [MAX_ITEMS];
	logic [KeyW-1:0] key_mem  [MAX_ITEMS];
	logic [AW-1:0]   link_mem [MAX_ITEMS];
	logic [AW-1:0]   head_q   [NUM_KEYS];
	logic [AW-1:0]   tail_q   [NUM_KEYS];
	logic [NUM_KEYS-1:0] nonempty_q;
	logic [CW-1:0]   count_q;
	logic            draining_q;
	logic [BW-1:0]   dbkt_q;
	logic [AW-1:0]   dptr_q;
	state_t          state_q;
	out_item_t       res_q;
	logic            res_valid_q;

	logic [IdW-1:0]  rd_id_q;
	logic [KeyW-1:0] rd_key_q;
	logic [AW-1:0]   rd_link_q;
	logic [AW-1:0]   rd_head_q;
	logic [AW-1:0]   rd_tail_q;
	logic            from_head_q;
	logic            link_pend_q;
	logic [AW-1:0]   link_slot_q;

	// load classification
	logic [KeyW:0]   diff;
	logic            in_range;
	logic [BW-1:0]   lb;
	assign diff     = {1'b0, q_item.record_key} - {1'b0, min_key};
	assign in_range = !diff[KeyW] && (diff < (KeyW+1)'(NUM_KEYS));
	assign lb       = diff[BW-1:0];

	// priority search over nonempty buckets from a start index
	logic [BW-1:0] first_b, next_b;
	logic          first_f, next_f;
	always_comb begin
		first_b = '0; first_f = 1'b0;
		for (int i = NUM_KEYS-1; i >= 0; i--) begin
			if (nonempty_q[i]) begin first_b = BW'(i); first_f = 1'b1; end
		end
		next_b = '0; next_f = 1'b0;
		for (int i = NUM_KEYS-1; i >= 0; i--) begin
			if (nonempty_q[i] && (BW'(i) > dbkt_q)) begin
				next_b = BW'(i); next_f = 1'b1;
			end
		end
	end

	logic free_out;
	assign free_out = !res_valid_q || out_ready;
	assign out_valid = res_valid_q;
	assign out_item  = res_q;
	assign q_pop = (state_q == S_IDLE) && q_valid && free_out;

	logic is_load, load_ok;
	assign is_load = !q_item.mode;
	assign load_ok = q_pop && is_load && !draining_q && in_range
		&& (count_q < CW'(MAX_ITEMS));

	// read addresses: bucket tables and record store
	logic [BW-1:0] head_ra, tail_ra;
	logic [AW-1:0] st_ra;
	assign head_ra = draining_q ? dbkt_q : first_b;
	assign tail_ra = (state_q == S_READ) ? dbkt_q : lb;
	assign st_ra   = (state_q == S_READ && from_head_q) ? rd_head_q : dptr_q;

	// status of a popped beat; a drain with records is overwritten at S_OUT
	status_t pop_st;
	always_comb begin
		if (!is_load) pop_st = ST_EMPTY;
		else if (draining_q) pop_st = ST_BUSY;
		else if (!in_range) pop_st = ST_RANGE;
		else if (count_q >= CW'(MAX_ITEMS)) pop_st = ST_FULL;
		else pop_st = ST_LOADED;
	end

	// record store writes and registered reads; the link to a new record
	// is written in the cycle after its load, at the tail read on the load
	always_ff @(posedge clk) begin
		if (load_ok) begin
			id_mem[count_q[AW-1:0]]  <= q_item.record_id;
			key_mem[count_q[AW-1:0]] <= q_item.record_key;
			link_slot_q <= count_q[AW-1:0];
		end
		if (link_pend_q) link_mem[rd_tail_q] <= link_slot_q;
		rd_id_q   <= id_mem[st_ra];
		rd_key_q  <= key_mem[st_ra];
		rd_link_q <= link_mem[st_ra];
	end

	// bucket head and tail tables, registered reads
	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (!nonempty_q[lb]) head_q[lb] <= count_q[AW-1:0];
			tail_q[lb] <= count_q[AW-1:0];
		end
		rd_head_q <= head_q[head_ra];
		rd_tail_q <= tail_q[tail_ra];
	end

	// result register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.status    <= pop_st;
			res_q.out_id    <= '0;
			res_q.out_key   <= '0;
			res_q.last_item <= 1'b0;
		end else if (state_q == S_OUT) begin
			res_q.status    <= ST_ITEM;
			res_q.out_id    <= rd_id_q;
			res_q.out_key   <= rd_key_q;
			res_q.last_item <= (dptr_q == rd_tail_q) && !next_f;
		end
	end

	// sequencer: a drain reads the store in S_READ, then emits in S_OUT
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; res_valid_q <= 1'b0; nonempty_q <= '0;
			count_q <= '0; draining_q <= 1'b0; dbkt_q <= '0; dptr_q <= '0;
			from_head_q <= 1'b0; link_pend_q <= 1'b0;
		end else begin
			link_pend_q <= load_ok && nonempty_q[lb];
			if (res_valid_q && out_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (is_load || count_q == '0) res_valid_q <= 1'b1;
						else begin
							state_q <= S_READ;
							if (!draining_q) begin
								draining_q <= 1'b1;
								dbkt_q <= first_b;
								from_head_q <= 1'b1;
							end
						end
						if (load_ok) begin
							nonempty_q[lb] <= 1'b1;
							count_q <= count_q + CW'(1);
						end
					end
				end
				S_READ: begin
					state_q <= S_OUT;
					if (from_head_q) begin
						dptr_q <= rd_head_q;
						from_head_q <= 1'b0;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
					res_valid_q <= 1'b1;
					if (dptr_q == rd_tail_q) begin
						if (!next_f) begin
							nonempty_q <= '0; count_q <= '0; draining_q <= 1'b0;
							dbkt_q <= '0; dptr_q <= '0;
						end else begin
							dbkt_q <= next_b; from_head_q <= 1'b1;
						end
					end else dptr_q <= rd_link_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS)) else $error("count overflow");
	a_drain_has: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> (count_q != '0) && first_f) else $error("drain with empty store");
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> first_f) else $error("records but no bucket");
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> free_out) else $error("result overwritten");
endmodule

// ===== hw/rtl/stable_bucket_sort.sv =====
// Stable bucket sort block: top level, config register and channel glue.
// Depends on sbs_pkg, sbs_if, sbs_front and sbs_back.
// Usage:
//  in  channel: mode 0 loads (record_id, record_key) into bucket key-min_key;
//               mode 1 drains the next record in ascending key order, arrival
//               order within a key.
//  out channel: one result beat per input beat: status, out_id, out_key,
//               last_item. The final record of a batch sets last_item and
//               clears the batch.
//  cfg channel: writes min_key (reset 18); write only while idle.
// A load or an error answers through the queue and the result register; a
// drain also passes the sequencer's read step (registered read of the record
// store and the bucket tail) and its emit step. Sustained rate: one load per
// cycle while results are taken; a drain holds the sequencer through both
// steps. The two-entry input queue accepts beats while a result waits.
// Reset empties all buckets and queues; no clearing pass is needed since the
// store is only read at entries written in the current batch.
// A stalled receiver holds the result register; the sequencer and then the
// queue fill and in.ready drops.
module stable_bucket_sort #(
	parameter int MAX_ITEMS = 1024,
	parameter int NUM_KEYS  = 64
) (
	input logic       clk,
	input logic       arst_n,
	sbs_in_if.sink    in_ch,
	sbs_out_if.source out_ch,
	sbs_cfg_if.sink   cfg
);
	import sbs_pkg::*;

	logic [KeyW-1:0] min_key_q;
	in_item_t  in_item, q_item;
	out_item_t out_item;
	logic      q_valid, q_pop;

	// config register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_key_q <= MinKeyReset;
		else if (cfg.valid) min_key_q <= cfg.data;
	end

	assign in_item.mode       = in_ch.mode;
	assign in_item.record_id  = in_ch.record_id;
	assign in_item.record_key = in_ch.record_key;

	sbs_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item,
		.q_valid, .q_pop, .q_item
	);

	sbs_back #(.MAX_ITEMS(MAX_ITEMS), .NUM_KEYS(NUM_KEYS)) u_back (
		.clk, .arst_n, .min_key(min_key_q),
		.q_valid, .q_pop, .q_item,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item
	);

	assign out_ch.status    = out_item.status;
	assign out_ch.out_id    = out_item.out_id;
	assign out_ch.out_key   = out_item.out_key;
	assign out_ch.last_item = out_item.last_item;
endmodule
